// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: lbl");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: lbl");

`endif

// File: rtl/core/grdda_pkg.sv
// Types, constants and helpers for the grid DDA ray caster.
`default_nettype none
package grdda_pkg;

   localparam int GRID_DIM_DEF  = 64;
   localparam int CELL_BITS_DEF = 8;

   localparam logic [12:0] STEP_LIMIT_RESET = 13'd256;
   localparam logic [15:0] D_MIN    = 16'd1024;
   localparam logic [15:0] D_MAX    = 16'd51200;
   localparam logic [16:0] DIST_MAX = 17'd102400;
   localparam logic [31:0] RECIP_NUM = 32'h0100_0000;
   localparam logic [10:0] ONE_Q10  = 11'd1024;

   localparam int DIV_NUM_W = 32;
   localparam int DIV_DEN_W = 16;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_CAST  = 1'b1;

   localparam logic [1:0] FACE_NORTH = 2'd0;
   localparam logic [1:0] FACE_SOUTH = 2'd1;
   localparam logic [1:0] FACE_WEST  = 2'd2;
   localparam logic [1:0] FACE_EAST  = 2'd3;

   typedef struct packed {
      logic               operation;
      logic [5:0]         cell_col;
      logic [5:0]         cell_row;
      logic [7:0]         cell_value;
      logic [15:0]        start_x;
      logic [15:0]        start_y;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
   } req_payload_type;

   typedef struct packed {
      logic [16:0] hit_distance;
      logic [1:0]  hit_face;
      logic [7:0]  hit_value;
      logic        hit_found;
   } rsp_payload_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_ctrl_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } div_stat_type;

   function automatic logic [15:0] clamp_step(input logic [DIV_NUM_W-1:0] q);
      logic [15:0] r;
      if (q < DIV_NUM_W'(D_MIN)) begin
         r = D_MIN;
      end else if (q > DIV_NUM_W'(D_MAX)) begin
         r = D_MAX;
      end else begin
         r = q[15:0];
      end
      return r;
   endfunction

   function automatic logic [16:0] clamp_dist(input logic [DIV_NUM_W-1:0] q);
      logic [16:0] r;
      if (q > DIV_NUM_W'(DIST_MAX)) begin
         r = DIST_MAX;
      end else begin
         r = q[16:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/grdda_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
`include "assert_macros.svh"
module grdda_div
   import grdda_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire div_ctrl_type ctrl,
   output div_stat_type      stat
);

   localparam int CNT_W = $clog2(DIV_NUM_W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   diff;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      trial    = {rem_ff, quo_ff[DIV_NUM_W-1]};
      diff     = trial - {1'b0, den_ff};
      if (ctrl.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = ctrl.dividend;
         den_in   = ctrl.divisor;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[DIV_DEN_W-1:0];
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_DEN_W-1:0];
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      den_ff   <= den_in;
   end

   assign stat.busy     = busy_ff;
   assign stat.done     = done_ff;
   assign stat.quotient = quo_ff;

   `ASSERT_IMPLY(a_done_not_busy, clock, reset, done_ff, !busy_ff)
   `ASSERT_NEXT(a_start_busy, clock, reset, ctrl.start, busy_ff)
   `ASSERT_IMPLY(a_start_idle, clock, reset, ctrl.start, !busy_ff)

endmodule
`default_nettype wire

// File: rtl/core/grid_ray_dda_cast.sv
// Grid map of cell values with a DDA ray caster.
//
// Usage: req_ carries one item per transfer. A write item (operation 0)
// stores cell_value at (cell_col, cell_row) and gives no result; a cast item
// (operation 1) walks the map from start_x/start_y along dir_x/dir_y and gives
// one result on rsp_. csr_ loads the step limit (reset value 256) at any time
// the block is idle.
// Sequence: a write is stored as it is taken. A cast runs the two reciprocals
// (a serial divider run per axis, skipped for a zero component), then each
// cell step (a map read in ST_READ, a compare-and-advance in ST_CHECK), then,
// for a hit past the start cell, the hit distance division.
// One item is in work at a time: req_ready is high only in ST_IDLE, so the
// next item is taken once the last has put its result in the output register.
// Reset: the map is swept to zero one cell per cycle, GRID_DIM*GRID_DIM cells
// (4096 by default); req_ready stays low meanwhile, csr_ writes are taken.
// Stall: the result sits in an output register until rsp_ready; the next item
// is accepted and worked on meanwhile and waits only to hand its result over.
`default_nettype none
`include "assert_macros.svh"
module grid_ray_dda_cast
   import grdda_pkg::*;
#(
   parameter int GRID_DIM  = GRID_DIM_DEF,
   parameter int CELL_BITS = CELL_BITS_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_payload,
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic [12:0]     csr_data
);

   localparam int DEPTH  = GRID_DIM * GRID_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int IDX_W  = $clog2(GRID_DIM);
   localparam int CX_W   = ((IDX_W > 6) ? IDX_W : 6) + 2;
   localparam int SIDE_W = 40;

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_DIVX  = 4'd2;
   localparam logic [3:0] ST_WAITX = 4'd3;
   localparam logic [3:0] ST_DIVY  = 4'd4;
   localparam logic [3:0] ST_WAITY = 4'd5;
   localparam logic [3:0] ST_SIDE  = 4'd6;
   localparam logic [3:0] ST_READ  = 4'd7;
   localparam logic [3:0] ST_CHECK = 4'd8;
   localparam logic [3:0] ST_DIST  = 4'd9;
   localparam logic [3:0] ST_WAITD = 4'd10;
   localparam logic [3:0] ST_DONE  = 4'd11;

   logic [CELL_BITS-1:0] grid_mem [DEPTH];

   logic [3:0]            state_ff, state_in;
   logic [ADDR_W-1:0]     clr_addr_ff, clr_addr_in;
   logic [12:0]           limit_ff;
   logic [15:0]           sx_ff, sx_in, sy_ff, sy_in;
   logic                  negx_ff, negx_in, negy_ff, negy_in;
   logic [15:0]           mx_ff, mx_in, my_ff, my_in;
   logic [15:0]           dx_ff, dx_in, dy_ff, dy_in;
   logic [SIDE_W-1:0]     side_x_ff, side_x_in, side_y_ff, side_y_in;
   logic signed [CX_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [12:0]           steps_ff, steps_in;
   logic                  yhit_ff, yhit_in;
   logic                  found_ff, found_in;
   logic [CELL_BITS-1:0]  val_ff, val_in;
   logic [16:0]           dist_ff, dist_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_ff, rsp_in;
   logic [CELL_BITS-1:0]  rdata_ff;

   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_waddr;
   logic [CELL_BITS-1:0]  mem_wdata;
   logic [ADDR_W-1:0]     mem_raddr;
   div_ctrl_type          div_ctrl;
   div_stat_type          div_stat;

   logic                  req_xfer;
   logic [10:0]           offx, offy;
   logic signed [CX_W-1:0] nx, ny, hit_cell;
   logic                  step_x, next_out;
   logic signed [20:0]    n_val;
   logic [17:0]           an;
   logic [15:0]           hit_m;
   logic                  hit_neg;
   logic [15:0]           hit_start;
   logic                  out_free;
   logic                  miss_clean;
   logic                  div_waiting;

   function automatic logic in_grid(input logic signed [CX_W-1:0] c);
      return (c >= 0) && (c < $signed(CX_W'(GRID_DIM)));
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign offx = negx_ff ? {1'b0, sx_ff[9:0]} : ONE_Q10 - {1'b0, sx_ff[9:0]};
   assign offy = negy_ff ? {1'b0, sy_ff[9:0]} : ONE_Q10 - {1'b0, sy_ff[9:0]};
   assign step_x = side_x_ff < side_y_ff;
   assign nx = negx_ff ? cx_ff - 1'b1 : cx_ff + 1'b1;
   assign ny = negy_ff ? cy_ff - 1'b1 : cy_ff + 1'b1;
   assign next_out = step_x ? !in_grid(nx) : !in_grid(ny);

   assign hit_cell  = yhit_ff ? cy_ff : cx_ff;
   assign hit_neg   = yhit_ff ? negy_ff : negx_ff;
   assign hit_start = yhit_ff ? sy_ff : sx_ff;
   assign hit_m     = yhit_ff ? my_ff : mx_ff;
   assign n_val = $signed({hit_cell[CX_W-1], hit_cell, 10'd0}) + (hit_neg ? 21'sd1024 : 21'sd0)
                  - $signed({5'd0, hit_start});
   assign an = n_val[20] ? 18'(-n_val) : n_val[17:0];

   assign mem_raddr = ADDR_W'(cy_ff[IDX_W-1:0]) * ADDR_W'(GRID_DIM)
                      + ADDR_W'(cx_ff[IDX_W-1:0]);

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = ADDR_W'(req_payload.cell_row) * ADDR_W'(GRID_DIM)
                  + ADDR_W'(req_payload.cell_col);
      mem_wdata = CELL_BITS'(req_payload.cell_value);
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else if (req_xfer && req_payload.operation == OP_WRITE
                   && 32'(req_payload.cell_col) < 32'(GRID_DIM)
                   && 32'(req_payload.cell_row) < 32'(GRID_DIM)) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= grid_mem[mem_raddr];
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      negx_in      = negx_ff;
      negy_in      = negy_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      side_x_in    = side_x_ff;
      side_y_in    = side_y_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      steps_in     = steps_ff;
      yhit_in      = yhit_ff;
      found_in     = found_ff;
      val_in       = val_ff;
      dist_in      = dist_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      div_ctrl.start    = 1'b0;
      div_ctrl.dividend = RECIP_NUM;
      div_ctrl.divisor  = mx_ff;

      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer && req_payload.operation == OP_CAST) begin
               sx_in    = req_payload.start_x;
               sy_in    = req_payload.start_y;
               negx_in  = req_payload.dir_x[15];
               negy_in  = req_payload.dir_y[15];
               mx_in    = req_payload.dir_x[15] ? 16'(-req_payload.dir_x) : req_payload.dir_x;
               my_in    = req_payload.dir_y[15] ? 16'(-req_payload.dir_y) : req_payload.dir_y;
               cx_in    = CX_W'(req_payload.start_x[15:10]);
               cy_in    = CX_W'(req_payload.start_y[15:10]);
               steps_in = '0;
               yhit_in  = 1'b0;
               found_in = 1'b0;
               val_in   = '0;
               dist_in  = '0;
               state_in = ST_DIVX;
            end
         end
         ST_DIVX: begin
            if (mx_ff == '0) begin
               dx_in    = D_MAX;
               state_in = ST_DIVY;
            end else begin
               div_ctrl.start = 1'b1;
               state_in       = ST_WAITX;
            end
         end
         ST_WAITX: begin
            if (div_stat.done) begin
               dx_in    = clamp_step(div_stat.quotient);
               state_in = ST_DIVY;
            end
         end
         ST_DIVY: begin
            div_ctrl.divisor = my_ff;
            if (my_ff == '0) begin
               dy_in    = D_MAX;
               state_in = ST_SIDE;
            end else begin
               div_ctrl.start = 1'b1;
               state_in       = ST_WAITY;
            end
         end
         ST_WAITY: begin
            if (div_stat.done) begin
               dy_in    = clamp_step(div_stat.quotient);
               state_in = ST_SIDE;
            end
         end
         ST_SIDE: begin
            side_x_in = SIDE_W'(offx) * SIDE_W'(dx_ff);
            side_y_in = SIDE_W'(offy) * SIDE_W'(dy_ff);
            // a start outside the map gives no hit
            state_in  = (in_grid(cx_ff) && in_grid(cy_ff)) ? ST_READ : ST_DONE;
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (rdata_ff != '0) begin
               val_in   = rdata_ff;
               found_in = 1'b1;
               state_in = (steps_ff == '0) ? ST_DONE : ST_DIST;
            end else if (steps_ff >= limit_ff) begin
               state_in = ST_DONE;
            end else begin
               steps_in = steps_ff + 1'b1;
               if (step_x) begin
                  side_x_in = side_x_ff + {14'd0, dx_ff, 10'd0};
                  cx_in     = nx;
                  yhit_in   = 1'b0;
               end else begin
                  side_y_in = side_y_ff + {14'd0, dy_ff, 10'd0};
                  cy_in     = ny;
                  yhit_in   = 1'b1;
               end
               state_in = next_out ? ST_DONE : ST_READ;
            end
         end
         ST_DIST: begin
            div_ctrl.dividend = {an[17:0], 14'd0};
            div_ctrl.divisor  = hit_m;
            if (hit_m == '0) begin
               dist_in  = DIST_MAX;
               state_in = ST_DONE;
            end else begin
               div_ctrl.start = 1'b1;
               state_in       = ST_WAITD;
            end
         end
         ST_WAITD: begin
            if (div_stat.done) begin
               dist_in  = clamp_dist(div_stat.quotient);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold the result until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (found_ff) begin
                  rsp_in.hit_distance = dist_ff;
                  rsp_in.hit_face     = yhit_ff ? (negy_ff ? FACE_SOUTH : FACE_NORTH)
                                                : (negx_ff ? FACE_EAST : FACE_WEST);
                  rsp_in.hit_value    = 8'(val_ff);
                  rsp_in.hit_found    = 1'b1;
               end else begin
                  rsp_in.hit_distance = '0;
                  rsp_in.hit_face     = FACE_NORTH;
                  rsp_in.hit_value    = '0;
                  rsp_in.hit_found    = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         limit_ff     <= STEP_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_data;
         end
      end
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
      negx_ff   <= negx_in;
      negy_ff   <= negy_in;
      mx_ff     <= mx_in;
      my_ff     <= my_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      side_x_ff <= side_x_in;
      side_y_ff <= side_y_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      steps_ff  <= steps_in;
      yhit_ff   <= yhit_in;
      found_ff  <= found_in;
      val_ff    <= val_in;
      dist_ff   <= dist_in;
      rsp_ff    <= rsp_in;
   end

   grdda_div u_div (
      .clock (clock),
      .reset (reset),
      .ctrl  (div_ctrl),
      .stat  (div_stat)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign miss_clean  = rsp_ff.hit_distance == '0 && rsp_ff.hit_face == FACE_NORTH
                        && rsp_ff.hit_value == '0;
   assign div_waiting = (state_ff == ST_WAITX || state_ff == ST_WAITY || state_ff == ST_WAITD)
                        && !div_stat.done;

   `ASSERT_IMPLY(a_dist_cap, clock, reset, rsp_valid_ff, rsp_ff.hit_distance <= DIST_MAX)
   `ASSERT_IMPLY(a_miss_zero, clock, reset, rsp_valid_ff && !rsp_ff.hit_found, miss_clean)
   `ASSERT_IMPLY(a_wait_busy, clock, reset, div_waiting, div_stat.busy)

endmodule
`default_nettype wire
